[hw/rtl/pfc_pkg.sv]
package pfc_pkg;

  // Texture format codes
  typedef enum logic [1:0] {
    FMT_5650 = 2'd0,
    FMT_5551 = 2'd1,
    FMT_4444 = 2'd2,
    FMT_8888 = 2'd3
  } pfc_fmt_e;

  // Configuration register indexes
  localparam logic [0:0] CFG_SRC_FORMAT = 1'b0;
  localparam logic [0:0] CFG_DST_FORMAT = 1'b1;

  localparam int unsigned PixelW = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 2;

  // Active formats, from the config registers to the datapath
  typedef struct packed {
    pfc_fmt_e src_format;
    pfc_fmt_e dst_format;
  } pfc_cfg_t;

  // One pixel with 8-bit channels
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pfc_rgba8_t;

  // Widening: repeat the top bits into the new low bits
  function automatic logic [7:0] widen5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] c);
    return {c, c[5:4]};
  endfunction

  function automatic logic [7:0] widen4(input logic [3:0] c);
    return {c, c};
  endfunction

  // Expand any format to 8 bits per channel
  function automatic pfc_rgba8_t unpack(input logic [31:0] p, input pfc_fmt_e fmt);
    pfc_rgba8_t ch;
    case (fmt)
      FMT_5650: begin
        ch.r = widen5(p[4:0]);
        ch.g = widen6(p[10:5]);
        ch.b = widen5(p[15:11]);
        ch.a = 8'hff;
      end
      FMT_5551: begin
        ch.r = widen5(p[4:0]);
        ch.g = widen5(p[9:5]);
        ch.b = widen5(p[14:10]);
        ch.a = {8{p[15]}};
      end
      FMT_4444: begin
        ch.r = widen4(p[3:0]);
        ch.g = widen4(p[7:4]);
        ch.b = widen4(p[11:8]);
        ch.a = widen4(p[15:12]);
      end
      default: begin
        ch = p;
      end
    endcase
    return ch;
  endfunction

  // Narrow to the target format, keeping the top bits of each channel
  function automatic logic [31:0] pack(input pfc_rgba8_t ch, input pfc_fmt_e fmt);
    logic [31:0] r;
    case (fmt)
      FMT_5650: r = {16'h0, ch.b[7:3], ch.g[7:2], ch.r[7:3]};
      FMT_5551: r = {16'h0, ch.a[7], ch.b[7:3], ch.g[7:3], ch.r[7:3]};
      FMT_4444: r = {16'h0, ch.a[7:4], ch.b[7:4], ch.g[7:4], ch.r[7:4]};
      default:  r = ch;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/pfc_pix_in_if.sv]
interface pfc_pix_in_if;
  import pfc_pkg::*;

  logic              valid;
  logic              ready;
  logic [PixelW-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

[hw/rtl/pfc_pix_out_if.sv]
interface pfc_pix_out_if;
  import pfc_pkg::*;

  logic              valid;
  logic              ready;
  logic [PixelW-1:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

[hw/rtl/pixel_format_converter_unit.sv]
// Channel   Direction  Handshake      Payload
// src_i     in         valid/ready    pixel_in  [31:0]
// dst_o     out        valid/ready    pixel_out [31:0]
// cfg       in         cfg_we_i       cfg_idx_i [0:0], cfg_wdata_i [1:0]
//
// One item per cycle while dst_o is not stalled. Data passes an input register,
// the conversion logic, then the result register that drives dst_o.
// Reset clears both valid flags and sets both formats to 8888.
// A stall on dst_o holds the result; the input stage still takes an item
// while it is empty, so the two stages fill before src_i.ready drops.
module pixel_format_converter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pfc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pfc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  pfc_pix_in_if.sink                    src_i,
  pfc_pix_out_if.source                 dst_o
);
  import pfc_pkg::*;

  pfc_cfg_t          cfg;
  logic              in_valid_q, in_valid_d;
  logic [PixelW-1:0] in_pix_q;
  logic              out_valid_q, out_valid_d;
  logic [PixelW-1:0] out_pix_q;
  logic [PixelW-1:0] conv_pix;
  logic              out_load;
  logic              in_load;

  pfc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pfc_convert u_convert (
    .cfg_i   (cfg),
    .pixel_i (in_pix_q),
    .pixel_o (conv_pix)
  );

  // Pipeline flow control
  assign out_load    = in_valid_q && (!out_valid_q || dst_o.ready);
  assign in_load     = src_i.valid && src_i.ready;
  assign src_i.ready = !in_valid_q || out_load;

  assign in_valid_d  = in_load || (in_valid_q && !out_load);
  assign out_valid_d = out_load || (out_valid_q && !dst_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_pix_q <= src_i.pixel_in;
    end
    if (out_load) begin
      out_pix_q <= conv_pix;
    end
  end

  assign dst_o.valid     = out_valid_q;
  assign dst_o.pixel_out = out_pix_q;

endmodule

[hw/rtl/pfc_cfg_regs.sv]
module pfc_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [pfc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pfc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output pfc_pkg::pfc_cfg_t        cfg_o
);
  import pfc_pkg::*;

  pfc_cfg_t cfg_q, cfg_d;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SRC_FORMAT: cfg_d.src_format = pfc_fmt_e'(cfg_wdata_i);
        CFG_DST_FORMAT: cfg_d.dst_format = pfc_fmt_e'(cfg_wdata_i);
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_format <= FMT_8888;
      cfg_q.dst_format <= FMT_8888;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/pfc_convert.sv]
module pfc_convert (
  input  pfc_pkg::pfc_cfg_t          cfg_i,
  input  logic [pfc_pkg::PixelW-1:0] pixel_i,
  output logic [pfc_pkg::PixelW-1:0] pixel_o
);
  import pfc_pkg::*;

  logic [PixelW-1:0] src_pix;
  pfc_rgba8_t        ch;
  logic [PixelW-1:0] conv_pix;

  // 16-bit sources ignore the upper half
  assign src_pix = (cfg_i.src_format == FMT_8888) ? pixel_i : {16'h0, pixel_i[15:0]};

  assign ch       = unpack(src_pix, cfg_i.src_format);
  assign conv_pix = pack(ch, cfg_i.dst_format);

  // Equal formats pass through; 16-bit results keep the upper half clear
  always_comb begin
    if (cfg_i.src_format == cfg_i.dst_format) begin
      pixel_o = src_pix;
    end else begin
      pixel_o = conv_pix;
    end
    if (cfg_i.dst_format != FMT_8888) begin
      pixel_o[31:16] = 16'h0;
    end
  end

endmodule
